/* rtl/core/rlpr_pkg.sv */
// Rod load peak and reversal: shared constants, register indexes and field widths.
// No dependencies; compiled first.

package rlpr_pkg;

    // Default parameter values
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_SAMPLES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 1'b1;

    // Register fields
    localparam int CYCLE_W  = 16;
    localparam int THRESH_W = 15;

    localparam logic [CYCLE_W-1:0]  CYCLE_SAMPLES_RST  = 16'd1024;
    localparam logic [THRESH_W-1:0] PEAK_THRESHOLD_RST = 15'd100;

    // Result fields
    localparam int TENSION_W = 15;
    localparam int COMP_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int INDEX_W   = 16;

    // Full circle in hundredths of a degree
    localparam int                 SCALE_W     = 16;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE = 16'd36000;

endpackage

/* rtl/core/rlpr_sample_if.sv */
// Sample request channel: valid/ready handshake with a signed rod-load sample.
// Depends on rlpr_pkg.

interface rlpr_sample_if #(
    parameter int SAMPLE_WIDTH = rlpr_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

/* rtl/core/rlpr_result_if.sv */
// Result request channel: valid/ready handshake with peaks, angle and end index.
// Depends on rlpr_pkg.

interface rlpr_result_if;
    logic                             valid;
    logic                             ready;
    logic [rlpr_pkg::TENSION_W-1:0]   peak_tension;
    logic [rlpr_pkg::COMP_W-1:0]      peak_compression;
    logic [rlpr_pkg::ANGLE_W-1:0]     reversal_angle;
    logic [rlpr_pkg::INDEX_W-1:0]     end_index;

    modport source (output valid, output peak_tension, output peak_compression,
                    output reversal_angle, output end_index, input ready);
    modport sink   (input valid, input peak_tension, input peak_compression,
                    input reversal_angle, input end_index, output ready);
endinterface

/* rtl/core/rod_load_peak_reversal.sv */
// Rod load peak and reversal block: window tracking, angle divider, output register.
// Depends on rlpr_pkg, rlpr_sample_if and rlpr_result_if.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    sample (signed), first
//   results   out  valid/ready    peak_tension, peak_compression, reversal_angle, end_index
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// A sample that does not close the window leaves ready high.
// The closing sample drops ready while it passes through the constant multiply,
// the restoring divider (one quotient bit per step) and the load into the output register.
// The result sits in an output register; new samples are taken while it waits,
// but a following window end holds until the register is free.
// Reset: cycle_samples 1024, peak_threshold 100, waiting for a first-marked sample.

module rod_load_peak_reversal #(
    parameter int SAMPLE_WIDTH = rlpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rlpr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rlpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    rlpr_sample_if.sink                         samples,
    rlpr_result_if.source                       results
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int CW        = COUNT_WIDTH;
    localparam int PROD_W    = CW + rlpr_pkg::SCALE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int EXT_W     = (SW + 1 > 16) ? SW + 1 : 16;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Configuration registers
    logic [rlpr_pkg::CYCLE_W-1:0]  cycle_samples_reg;
    logic [rlpr_pkg::THRESH_W-1:0] peak_threshold_reg;

    // Window state
    logic [1:0]           state_reg, state_next;
    logic signed [SW-1:0] max_reg, max_next;
    logic signed [SW-1:0] min_reg, min_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        seen_reg, seen_next;
    logic                 done_reg, done_next;

    // Divider
    logic [CW-1:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    logic [rlpr_pkg::TENSION_W-1:0]     tension_reg, tension_next;
    logic [rlpr_pkg::COMP_W-1:0]        comp_reg, comp_next;
    logic [rlpr_pkg::ANGLE_W-1:0]       angle_reg, angle_next;
    logic [rlpr_pkg::INDEX_W-1:0]       index_reg, index_next;

    // Helpers
    logic [CW+15:0]       cyc_wide;
    logic [CW-1:0]        n_raw;
    logic [CW-1:0]        n_len;
    logic [CW+15:0]       idx_wide;
    logic                 in_acc;
    logic                 win_open;
    logic [CW-1:0]        seen_base;
    logic [CW-1:0]        pos_base;
    logic [CW-1:0]        seen_inc;
    logic                 s_pos;
    logic [CW:0]          trial;
    logic [CW:0]          diff;
    logic signed [EXT_W-1:0] max_ext;
    logic signed [EXT_W-1:0] min_ext;
    logic [EXT_W-1:0]     tension_ext;
    logic [EXT_W-1:0]     comp_ext;
    logic                 thr_hit;
    logic                 out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_samples_reg  <= rlpr_pkg::CYCLE_SAMPLES_RST;
            peak_threshold_reg <= rlpr_pkg::PEAK_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlpr_pkg::REG_CYCLE_SAMPLES:
                    cycle_samples_reg <= cfg_data[rlpr_pkg::CYCLE_W-1:0];
                rlpr_pkg::REG_PEAK_THRESHOLD:
                    peak_threshold_reg <= cfg_data[rlpr_pkg::THRESH_W-1:0];
                default:
                    cycle_samples_reg <= cycle_samples_reg;
            endcase
        end
    end

    // Window length, zero treated as one
    assign cyc_wide = {{CW{1'b0}}, cycle_samples_reg};
    assign n_raw    = cyc_wide[CW-1:0];
    assign n_len    = (n_raw == '0) ? CW'(1) : n_raw;
    assign idx_wide = {16'b0, CW'(n_len - CW'(1))};

    // Input side
    assign samples.ready = (state_reg == ST_IDLE);
    assign in_acc        = samples.valid && samples.ready;
    assign win_open      = samples.first || !done_reg;
    assign seen_base     = samples.first ? '0 : seen_reg;
    assign pos_base      = samples.first ? '0 : pos_reg;
    assign seen_inc      = seen_base + CW'(1);
    assign s_pos         = !samples.sample[SW-1] && (samples.sample != '0);

    // Divider step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, n_len};

    // Peaks from window extremes
    assign max_ext     = EXT_W'(max_reg);
    assign min_ext     = EXT_W'(min_reg);
    assign tension_ext = (max_ext > 0) ? $unsigned(max_ext) : '0;
    assign comp_ext    = (min_ext < 0) ? $unsigned(-min_ext) : '0;
    assign thr_hit     = (tension_ext > EXT_W'(peak_threshold_reg))
                      || (comp_ext > EXT_W'(peak_threshold_reg));
    assign out_free    = !out_valid_reg || results.ready;

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        done_next      = done_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !results.ready;
        tension_next   = tension_reg;
        comp_next      = comp_reg;
        angle_next     = angle_reg;
        index_next     = index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && win_open)
                begin
                    if (seen_base == '0)
                    begin
                        max_next = samples.sample;
                        min_next = samples.sample;
                    end
                    else
                    begin
                        if (samples.sample > max_reg)
                            max_next = samples.sample;
                        if (samples.sample < min_reg)
                            min_next = samples.sample;
                    end
                    pos_next  = pos_base + {{(CW-1){1'b0}}, s_pos};
                    seen_next = seen_inc;
                    done_next = 1'b0;
                    if (seen_inc == n_len)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // Scale positive count to hundredths of a degree
                quo_next   = PROD_W'(pos_reg) * PROD_W'(rlpr_pkg::ANGLE_SCALE);
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!diff[CW])
                begin
                    rem_next = diff[CW-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tension_next   = tension_ext[rlpr_pkg::TENSION_W-1:0];
                    comp_next      = comp_ext[rlpr_pkg::COMP_W-1:0];
                    angle_next     = thr_hit ? quo_reg[rlpr_pkg::ANGLE_W-1:0] : '0;
                    index_next     = idx_wide[rlpr_pkg::INDEX_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seen_reg      <= '0;
            done_reg      <= 1'b1;
            max_reg       <= '0;
            min_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        tension_reg <= tension_next;
        comp_reg    <= comp_next;
        angle_reg   <= angle_next;
        index_reg   <= index_next;
    end

    // Result channel
    assign results.valid            = out_valid_reg;
    assign results.peak_tension     = tension_reg;
    assign results.peak_compression = comp_reg;
    assign results.reversal_angle   = angle_reg;
    assign results.end_index        = index_reg;

    // Checks
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == LAST_STEP) |=> (state_reg == ST_OUT))
        else $error("divider did not hand over after its last step");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output step");

    a_ignored_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !samples.first && done_reg) |=> (state_reg == ST_IDLE))
        else $error("sample outside a window started work");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < n_len))
        else $error("partial remainder not below divisor");

endmodule
